[hdl/rsd_pkg.sv]
package rsd_pkg;

  // framing marks and lengths
  localparam logic [7:0] MARK_SECTION = 8'h55;
  localparam logic [7:0] MARK_END     = 8'h07;
  localparam logic [7:0] MARK_RECORD  = 8'h80;

  localparam int RECORD_LEN      = 43;
  localparam int SECTION_LEN     = 255;
  localparam int HEADER_LEN      = 8;
  localparam int SECTION_HDR_LEN = 3;
  localparam int TOTALS_LEN      = 25;
  localparam int TOTALS_KEEP     = 6;

  localparam logic [7:0] SECTION_ROOM = 8'(SECTION_LEN - SECTION_HDR_LEN);

  // result kinds
  localparam logic [1:0] KIND_RECORD = 2'd0;
  localparam logic [1:0] KIND_TOTALS = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // queue between the parser and the emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TIDX_W = $clog2(TOTALS_KEEP);

  // one queued word: a record byte or an error
  typedef struct packed {
    logic [7:0]  data;
    logic [1:0]  kind;
    logic [15:0] index;
    logic        first;
    logic        closes;   // last record byte, totals follow
  } cmd_t;

  // write of one kept totals byte
  typedef struct packed {
    logic              we;
    logic [TIDX_W-1:0] idx;
    logic [7:0]        data;
  } tot_wr_t;

  // padding after the data of a section, saturated at zero
  function automatic logic [7:0] pad_len(input logic [7:0] dlen);
    pad_len = (dlen <= SECTION_ROOM) ? SECTION_ROOM - dlen : 8'd0;
  endfunction

endpackage

[hdl/rsd_front.sv]
module rsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            full,
  input  logic [7:0]      in_byte,
  output logic            push,
  output rsd_pkg::cmd_t   cmd,
  output rsd_pkg::tot_wr_t tot_wr
);
  import rsd_pkg::*;

  localparam logic [3:0] PH_START      = 4'd0;
  localparam logic [3:0] PH_HDR        = 4'd1;
  localparam logic [3:0] PH_FIRST_MARK = 4'd2;
  localparam logic [3:0] PH_FIRST_NUM  = 4'd3;
  localparam logic [3:0] PH_FIRST_LEN  = 4'd4;
  localparam logic [3:0] PH_TOTALS     = 4'd5;
  localparam logic [3:0] PH_MARK       = 4'd6;
  localparam logic [3:0] PH_NUM        = 4'd7;
  localparam logic [3:0] PH_LEN        = 4'd8;
  localparam logic [3:0] PH_DATA       = 4'd9;
  localparam logic [3:0] PH_PAD        = 4'd10;
  localparam logic [3:0] PH_DONE       = 4'd11;
  localparam logic [3:0] PH_HALT       = 4'd12;

  localparam logic [7:0] HDR_COUNT_AT = 8'(HEADER_LEN - 3);
  localparam logic [7:0] TOT_LEN8     = 8'(TOTALS_LEN);
  localparam logic [5:0] FILL_LAST    = 6'(RECORD_LEN - 1);

  logic [3:0]  phase, phase_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  sections_total, sections_total_next;
  logic [7:0]  sections_done, sections_done_next;
  logic [7:0]  data_length, data_length_next;
  logic [5:0]  record_fill, record_fill_next;
  logic [15:0] record_count, record_count_next;

  logic        accept;
  logic [7:0]  left_dec;
  logic [7:0]  pad_cur;
  logic [7:0]  pad_new;
  logic [7:0]  body_first;
  logic [7:0]  done_inc;
  logic        rec_first;

  assign accept     = in_valid && !full;
  assign left_dec   = bytes_left - 8'd1;
  assign pad_cur    = pad_len(data_length);
  assign pad_new    = pad_len(in_byte);
  assign body_first = (data_length > TOT_LEN8) ? data_length - TOT_LEN8 : 8'd0;
  assign done_inc   = (sections_done != 8'hff) ? sections_done + 8'd1 : sections_done;
  assign rec_first  = (in_byte == MARK_RECORD) && (record_fill == 6'd0);

  // parser
  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    sections_total_next = sections_total;
    sections_done_next  = sections_done;
    data_length_next    = data_length;
    record_fill_next    = record_fill;
    record_count_next   = record_count;
    push                = 1'b0;
    cmd.data            = 8'd0;
    cmd.kind            = KIND_ERROR;
    cmd.index           = record_count;
    cmd.first           = 1'b0;
    cmd.closes          = 1'b0;
    tot_wr.we           = 1'b0;
    tot_wr.idx          = '0;
    tot_wr.data         = in_byte;
    if (accept) begin
      unique case (phase)
        PH_START: begin
          if (in_byte != MARK_SECTION) begin
            push       = 1'b1;
            phase_next = PH_HALT;
          end else begin
            phase_next      = PH_HDR;
            bytes_left_next = 8'(HEADER_LEN - 1);
          end
        end
        PH_HDR: begin
          if (bytes_left == HDR_COUNT_AT) sections_total_next = in_byte;
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) phase_next = PH_FIRST_MARK;
        end
        PH_FIRST_MARK: begin
          if (in_byte != MARK_SECTION) begin
            push       = 1'b1;
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_FIRST_NUM;
          end
        end
        PH_FIRST_NUM: phase_next = PH_FIRST_LEN;
        PH_FIRST_LEN: begin
          data_length_next = in_byte;
          phase_next       = PH_TOTALS;
          bytes_left_next  = TOT_LEN8;
        end
        PH_TOTALS: begin
          // keep time bytes 3..5 and calorie bytes 9..11
          case (bytes_left)
            8'd22: begin tot_wr.we = 1'b1; tot_wr.idx = TIDX_W'(0); end
            8'd21: begin tot_wr.we = 1'b1; tot_wr.idx = TIDX_W'(1); end
            8'd20: begin tot_wr.we = 1'b1; tot_wr.idx = TIDX_W'(2); end
            8'd16: begin tot_wr.we = 1'b1; tot_wr.idx = TIDX_W'(3); end
            8'd15: begin tot_wr.we = 1'b1; tot_wr.idx = TIDX_W'(4); end
            8'd14: begin tot_wr.we = 1'b1; tot_wr.idx = TIDX_W'(5); end
            default: tot_wr.we = 1'b0;
          endcase
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            if (sections_total == 8'd0) begin
              phase_next = PH_DONE;
            end else if (body_first != 8'd0) begin
              phase_next      = PH_DATA;
              bytes_left_next = body_first;
            end else if (pad_cur != 8'd0) begin
              phase_next      = PH_PAD;
              bytes_left_next = pad_cur;
            end else begin
              phase_next = PH_MARK;
            end
          end
        end
        PH_DATA: begin
          if (rec_first || record_fill != 6'd0) begin
            push      = 1'b1;
            cmd.data  = in_byte;
            cmd.kind  = KIND_RECORD;
            cmd.first = rec_first;
            if (record_fill == FILL_LAST) begin
              cmd.closes        = 1'b1;
              record_fill_next  = 6'd0;
              record_count_next = record_count + 16'd1;
            end else begin
              record_fill_next = record_fill + 6'd1;
            end
          end
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) begin
            if (pad_cur != 8'd0) begin
              phase_next      = PH_PAD;
              bytes_left_next = pad_cur;
            end else begin
              phase_next = PH_MARK;
            end
          end
        end
        PH_PAD: begin
          bytes_left_next = left_dec;
          if (left_dec == 8'd0) phase_next = PH_MARK;
        end
        PH_MARK: begin
          if (in_byte != MARK_SECTION && in_byte != MARK_END) begin
            push       = 1'b1;
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_NUM;
          end
        end
        PH_NUM: phase_next = PH_LEN;
        PH_LEN: begin
          data_length_next   = in_byte;
          sections_done_next = done_inc;
          if (done_inc >= sections_total) begin
            phase_next = PH_DONE;
          end else if (in_byte != 8'd0) begin
            phase_next      = PH_DATA;
            bytes_left_next = in_byte;
          end else if (pad_new != 8'd0) begin
            phase_next      = PH_PAD;
            bytes_left_next = pad_new;
          end else begin
            phase_next = PH_MARK;
          end
        end
        default: phase_next = phase;
      endcase
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_START;
      bytes_left     <= 8'd0;
      sections_total <= 8'd0;
      sections_done  <= 8'd0;
      data_length    <= 8'd0;
      record_fill    <= 6'd0;
      record_count   <= 16'd0;
    end else begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      sections_total <= sections_total_next;
      sections_done  <= sections_done_next;
      data_length    <= data_length_next;
      record_fill    <= record_fill_next;
      record_count   <= record_count_next;
    end
  end

endmodule

[hdl/rsd_queue.sv]
module rsd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rsd_pkg::cmd_t push_cmd,
  input  logic          pop,
  output logic          full,
  output logic          head_valid,
  output rsd_pkg::cmd_t head
);
  import rsd_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  // word storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !do_pop) count <= count + QCNT_W'(1);
      else if (!push && do_pop) count <= count - QCNT_W'(1);
    end
  end

endmodule

[hdl/rsd_back.sv]
module rsd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  rsd_pkg::cmd_t    head,
  input  rsd_pkg::tot_wr_t tot_wr,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic [7:0]       out_byte,
  output logic [1:0]       kind,
  output logic [15:0]      record_index,
  output logic             first_of_record,
  output logic             last_of_record
);
  import rsd_pkg::*;

  localparam logic [2:0] TOT_LAST = 3'(TOTALS_KEEP);

  logic [7:0]        totals_bytes [TOTALS_KEEP];
  logic [2:0]        tot_cnt;
  logic              load;
  logic [TIDX_W-1:0] tot_idx;

  assign load    = !out_valid || !out_stall;
  assign tot_idx = TIDX_W'(tot_cnt - 3'd1);
  assign pop     = load && head_valid &&
                   ((tot_cnt == 3'd0 && !head.closes) || tot_cnt == TOT_LAST);

  // kept totals bytes
  always_ff @(posedge clk) begin
    if (tot_wr.we) totals_bytes[tot_wr.idx] <= tot_wr.data;
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (tot_cnt != 3'd0) begin
        out_byte        <= totals_bytes[tot_idx];
        kind            <= KIND_TOTALS;
        record_index    <= head.index;
        first_of_record <= 1'b0;
        last_of_record  <= (tot_cnt == TOT_LAST);
      end else begin
        out_byte        <= head.data;
        kind            <= head.kind;
        record_index    <= head.index;
        first_of_record <= head.first;
        last_of_record  <= 1'b0;
      end
    end
  end

  // output valid and totals sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      tot_cnt   <= 3'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        if (tot_cnt == TOT_LAST) tot_cnt <= 3'd0;
        else if (tot_cnt != 3'd0 || head.closes) tot_cnt <= tot_cnt + 3'd1;
      end
    end
  end

endmodule

[hdl/record_extracting_section_deframer_unit.sv]
// path: an accepted input word is registered in a queue slot, then in the output register
// throughput: one input word per cycle while the queue is not full; a record's closing
//   byte yields the byte plus six totals words, which the emitter serializes
// in_stall rises while the four-entry queue between parser and emitter is full
// reset: synchronous, clears parser, queue and output control; kept totals are not cleared
module record_extracting_section_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [1:0]  kind,
  output logic [15:0] record_index,
  output logic        first_of_record,
  output logic        last_of_record
);
  import rsd_pkg::*;

  logic    push;
  cmd_t    push_cmd;
  tot_wr_t tot_wr;
  logic    full;
  logic    head_valid;
  cmd_t    head;
  logic    pop;

  assign in_stall = full;

  // parser
  rsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .full     (full),
    .in_byte  (in_byte),
    .push     (push),
    .cmd      (push_cmd),
    .tot_wr   (tot_wr)
  );

  // decoupling queue
  rsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  // emitter
  rsd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head            (head),
    .tot_wr          (tot_wr),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .kind            (kind),
    .record_index    (record_index),
    .first_of_record (first_of_record),
    .last_of_record  (last_of_record)
  );

endmodule

[tb/sv/record_extracting_section_deframer_unit_tb.sv]
module record_extracting_section_deframer_unit_tb;
  import rsd_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 16;
  localparam int TRAIL_BYTES  = 6;

  // parser stages of the dump
  typedef enum logic [3:0] {
    ST_START, ST_HEADER, ST_FIRST_MARK, ST_FIRST_NUM, ST_FIRST_LEN, ST_TOTALS,
    ST_MARK, ST_NUM, ST_LEN, ST_DATA, ST_PAD, ST_DONE, ST_HALT
  } parse_stage_t;

  // one output word as expected
  typedef struct packed {
    logic [7:0]  value;
    logic [1:0]  kind;
    logic [15:0] index;
    logic        opens;
    logic        closes;
  } deframe_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte;
  logic [1:0]  kind;
  logic [15:0] record_index;
  logic        first_of_record;
  logic        last_of_record;

  // parser shadow state
  parse_stage_t stage = ST_START;
  logic [7:0]   count_down = 8'd0;
  logic [7:0]   section_goal = 8'd0;
  logic [7:0]   sections_seen = 8'd0;
  logic [7:0]   section_len = 8'd0;
  logic [5:0]   rec_pos = 6'd0;
  logic [15:0]  rec_number = 16'd0;
  logic [7:0]   kept_totals [TOTALS_KEEP];

  deframe_word_t pending_words[$];

  int unsigned idle_pct = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned sections_sent = 0;
  int unsigned words_checked = 0;
  int unsigned records_checked = 0;
  int unsigned mismatches = 0;

  record_extracting_section_deframer_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .kind            (kind),
    .record_index    (record_index),
    .first_of_record (first_of_record),
    .last_of_record  (last_of_record)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected",
               cycle_count, pending_words.size());
      $display("FAIL record_extracting_section_deframer_unit");
      $finish;
    end
  end

  // output stall in random bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left = stall_left - 1;
    end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each accepted word with the oldest expectation
  always @(posedge clk) begin : check_words
    deframe_word_t want;
    if (!rst && out_valid && !out_stall) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %0h kind %0d record_index %0d",
               out_byte, kind, record_index);
        mismatches++;
      end else begin
        want = pending_words.pop_front();
        if (want.closes) records_checked++;
        if (out_byte !== want.value) begin
          $error("out_byte: expected %0h, got %0h", want.value, out_byte);
          mismatches++;
        end
        if (kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, kind);
          mismatches++;
        end
        if (record_index !== want.index) begin
          $error("record_index: expected %0d, got %0d", want.index, record_index);
          mismatches++;
        end
        if (first_of_record !== want.opens) begin
          $error("first_of_record: expected %0b, got %0b", want.opens, first_of_record);
          mismatches++;
        end
        if (last_of_record !== want.closes) begin
          $error("last_of_record: expected %0b, got %0b", want.closes, last_of_record);
          mismatches++;
        end
      end
    end
  end

  function automatic void queue_word(input logic [7:0] value, input logic [1:0] kind_code,
                                     input logic opens, input logic closes);
    pending_words.push_back('{value: value, kind: kind_code, index: rec_number,
                              opens: opens, closes: closes});
  endfunction

  // padding after section data, zero when the data fills the section
  function automatic void start_pad();
    logic [7:0] pad;
    pad = (section_len <= SECTION_ROOM) ? SECTION_ROOM - section_len : 8'd0;
    if (pad != 0) begin
      stage = ST_PAD;
      count_down = pad;
    end else begin
      stage = ST_MARK;
    end
  endfunction

  function automatic void start_body(input logic [7:0] data_bytes);
    if (data_bytes != 0) begin
      stage = ST_DATA;
      count_down = data_bytes;
    end else begin
      start_pad();
    end
  endfunction

  // advance the shadow parser by one byte and queue the words it yields
  function automatic void parse_byte(input logic [7:0] b);
    int unsigned pos;
    logic opens;
    int k;
    case (stage)
      ST_START: begin
        if (b != MARK_SECTION) begin
          queue_word(8'h00, KIND_ERROR, 1'b0, 1'b0);
          stage = ST_HALT;
        end else begin
          stage = ST_HEADER;
          count_down = 8'(HEADER_LEN - 1);
        end
      end
      ST_HEADER: begin
        if (count_down == 8'(HEADER_LEN - 3)) section_goal = b;
        if (count_down != 0) count_down--;
        if (count_down == 0) stage = ST_FIRST_MARK;
      end
      ST_FIRST_MARK: begin
        if (b != MARK_SECTION) begin
          queue_word(8'h00, KIND_ERROR, 1'b0, 1'b0);
          stage = ST_HALT;
        end else begin
          stage = ST_FIRST_NUM;
        end
      end
      ST_FIRST_NUM: stage = ST_FIRST_LEN;
      ST_FIRST_LEN: begin
        section_len = b;
        stage = ST_TOTALS;
        count_down = 8'(TOTALS_LEN);
      end
      ST_TOTALS: begin
        // time bytes 3..5 and calorie bytes 9..11 are kept
        pos = TOTALS_LEN - count_down;
        if (pos >= 3 && pos <= 5) kept_totals[pos - 3] = b;
        else if (pos >= 9 && pos <= 11) kept_totals[pos - 6] = b;
        if (count_down != 0) count_down--;
        if (count_down == 0) begin
          if (section_goal == 0) stage = ST_DONE;
          else start_body(section_len > 8'(TOTALS_LEN) ? section_len - 8'(TOTALS_LEN) : 8'd0);
        end
      end
      ST_DATA: begin
        opens = (b == MARK_RECORD) && (rec_pos == 0);
        if (opens || rec_pos != 0) begin
          queue_word(b, KIND_RECORD, opens, 1'b0);
          rec_pos++;
          if (rec_pos >= RECORD_LEN) begin
            for (k = 0; k < TOTALS_KEEP; k++)
              queue_word(kept_totals[k], KIND_TOTALS, 1'b0, k == TOTALS_KEEP - 1);
            rec_pos = 0;
            rec_number++;
          end
        end
        if (count_down != 0) count_down--;
        if (count_down == 0) start_pad();
      end
      ST_PAD: begin
        if (count_down != 0) count_down--;
        if (count_down == 0) stage = ST_MARK;
      end
      ST_MARK: begin
        if (b != MARK_SECTION && b != MARK_END) begin
          queue_word(8'h00, KIND_ERROR, 1'b0, 1'b0);
          stage = ST_HALT;
        end else begin
          stage = ST_NUM;
        end
      end
      ST_NUM: stage = ST_LEN;
      ST_LEN: begin
        section_len = b;
        if (sections_seen < 8'd255) sections_seen++;
        if (sections_seen >= section_goal) stage = ST_DONE;
        else start_body(section_len);
      end
      default: ;
    endcase
  endfunction

  // send one word, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b);
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    parse_byte(b);
  endtask

  // section body: records open often, so most data is well-formed records
  function automatic logic [7:0] body_byte();
    if (stage == ST_DATA && rec_pos == 0 && $urandom_range(0, 2) == 0)
      return MARK_RECORD;
    return 8'($urandom);
  endfunction

  // dump header: start byte, skipped bytes at extremes, largest section count
  task automatic test_dump_header();
    send_byte(MARK_SECTION);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'd255);
    repeat (4) send_byte(8'($urandom));
  endtask

  // first section shorter than its totals block, kept totals at extremes
  task automatic test_short_first_section();
    int t;
    send_byte(MARK_SECTION);
    send_byte(8'($urandom));
    send_byte(8'd20);
    sections_sent++;
    for (t = 0; t < TOTALS_LEN; t++) begin
      case (t)
        3, 10:   send_byte(8'h00);
        4, 9:    send_byte(8'hFF);
        default: send_byte(8'($urandom));
      endcase
    end
    while (stage == ST_PAD) send_byte(8'($urandom));
  endtask

  // records: noise before, start byte inside a record, back to back,
  // and one running across the section end
  task automatic test_record_framing();
    logic [7:0] b;
    send_byte(MARK_END);
    send_byte(8'($urandom));
    send_byte(SECTION_ROOM);
    sections_sent++;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h7F);
    send_byte(8'h81);
    send_byte(MARK_RECORD);
    send_byte(MARK_RECORD);
    send_byte(8'h00);
    send_byte(8'hFF);
    repeat (RECORD_LEN - 4) send_byte(8'($urandom));
    send_byte(MARK_RECORD);
    repeat (RECORD_LEN - 1) send_byte(8'($urandom));
    while (count_down > 10) begin
      do b = 8'($urandom); while (b == MARK_RECORD);
      send_byte(b);
    end
    send_byte(MARK_RECORD);
    while (stage == ST_DATA) send_byte(8'($urandom));
  endtask

  // overlong section: finishes the open record, padding saturates at zero;
  // its tail runs at full rate
  task automatic test_overlong_section();
    idle_pct = 40;
    send_byte(MARK_SECTION);
    send_byte(8'($urandom));
    send_byte(8'd255);
    sections_sent++;
    while (stage == ST_DATA || stage == ST_PAD) begin
      if (count_down == 8'd96) idle_pct = 0;
      send_byte(body_byte());
    end
  endtask

  // a bad section marker halts the parser, later words yield nothing
  task automatic test_bad_marker();
    logic [7:0] bad;
    idle_pct = 0;
    do bad = 8'($urandom); while (bad == MARK_SECTION || bad == MARK_END);
    send_byte(bad);
    repeat (TRAIL_BYTES) send_byte(MARK_RECORD);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 20;
    test_dump_header();
    test_short_first_section();
    test_record_framing();
    test_overlong_section();
    test_bad_marker();
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d bytes in %0d sections, ending on a bad section marker",
             bytes_sent, sections_sent);
    $display("checked %0d output words, %0d complete records with totals",
             words_checked, records_checked);
    if (mismatches == 0) begin
      $display("PASS record_extracting_section_deframer_unit");
    end else begin
      $display("FAIL record_extracting_section_deframer_unit");
    end
    $finish;
  end

endmodule
